FILE: rtl/core/bss_pkg.sv
package bss_pkg;

    localparam int SAMPLE_BITS = 16;

    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [CFG_IDX_BITS-1:0] REG_SCALE_X    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SCALE_Y    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_OFFSET_X   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_OFFSET_Y   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_SRC_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_SRC_HEIGHT = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_ND_ENABLE  = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_ND_VALUE   = 3'd7;

    localparam int IDX_BITS = 13;
    localparam int SIZE_BITS = 14;
    localparam int FRAC_BITS = 16;

    // Classified item handed from the front part to the back part.
    typedef struct packed {
        logic [IDX_BITS-1:0]  x0;
        logic [IDX_BITS-1:0]  x1;
        logic [IDX_BITS-1:0]  y0;
        logic [IDX_BITS-1:0]  y1;
        logic [FRAC_BITS-1:0] fx;
        logic [FRAC_BITS-1:0] fy;
        logic                 nd_path;
        logic [2:0]           nd_count;
        logic [17:0]          nd_sum;
        logic [63:0]          samples;
    } bss_item_t;

endpackage

FILE: rtl/core/bss_axis_map.sv
module bss_axis_map (
    input  logic        aclk,
    input  logic        en,
    input  logic [15:0] dest,
    input  logic [31:0] scale,
    input  logic [31:0] offset,
    input  logic [13:0] size,
    output logic [12:0] i0,
    output logic [12:0] i1,
    output logic [15:0] frac
);
    import bss_pkg::*;

    // Stage 1: one 17x32 product; stage 2: position, floor and clamp.
    logic [48:0] prod_reg;
    logic [31:0] offset_reg;
    logic [13:0] last_reg;
    logic [13:0] last_next;
    logic signed [50:0] pos;
    logic signed [34:0] idx;
    logic [12:0] a;

    always_comb begin
        if (size == 14'd0) begin
            last_next = 14'd0;
        end else if (size > 14'd8192) begin
            last_next = 14'd8191;
        end else begin
            last_next = size - 14'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg   <= {dest, 1'b1} * scale;
            offset_reg <= offset;
            last_reg   <= last_next;
        end
    end

    always_comb begin
        pos = $signed({{19{offset_reg[31]}}, offset_reg})
            + $signed({3'b000, prod_reg[48:1]}) - 51'sd32768;
        idx = pos[50:16];
        frac = pos[15:0];
        if (idx < 0) begin
            a  = '0;
            i0 = '0;
            i1 = '0;
        end else begin
            a  = (idx > $signed({21'd0, last_reg})) ? last_reg[12:0] : idx[12:0];
            i0 = a;
            i1 = ({1'b0, a} + 14'd1 > last_reg) ? last_reg[12:0] : a + 13'd1;
        end
    end
endmodule

FILE: rtl/core/bss_front.sv
module bss_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [95:0]         in_data,
    input  logic [31:0]         scale_x,
    input  logic [31:0]         scale_y,
    input  logic [31:0]         offset_x,
    input  logic [31:0]         offset_y,
    input  logic [13:0]         src_width,
    input  logic [13:0]         src_height,
    input  logic                nd_enable,
    input  logic [15:0]         nd_value,
    output logic                out_valid,
    input  logic                out_ready,
    output bss_pkg::bss_item_t  out_item
);
    import bss_pkg::*;

    // Two-stage pipeline; advances as a whole when its tail is free.
    logic        v1_reg, v2_reg;
    logic        adv;
    logic [63:0] smp_reg;
    logic        ndp_reg;
    logic [2:0]  cnt_reg;
    logic [17:0] sum_reg;
    logic [2:0]  cnt_next;
    logic [17:0] sum_next;
    logic        any_nd;
    logic [12:0] x0, x1, y0, y1;
    logic [15:0] fx, fy;
    bss_item_t   item_reg;

    assign adv = !v2_reg || out_ready;
    assign in_ready = adv;

    always_comb begin
        any_nd = 1'b0;
        cnt_next = '0;
        sum_next = '0;
        for (int k = 0; k < 4; k++) begin
            if (in_data[32+16*k +: 16] == nd_value) begin
                any_nd = 1'b1;
            end else begin
                cnt_next = cnt_next + 3'd1;
                sum_next = sum_next + {2'b00, in_data[32+16*k +: 16]};
            end
        end
    end

    bss_axis_map u_map_x (
        .aclk(aclk), .en(adv), .dest(in_data[15:0]), .scale(scale_x),
        .offset(offset_x), .size(src_width), .i0(x0), .i1(x1), .frac(fx)
    );
    bss_axis_map u_map_y (
        .aclk(aclk), .en(adv), .dest(in_data[31:16]), .scale(scale_y),
        .offset(offset_y), .size(src_height), .i0(y0), .i1(y1), .frac(fy)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            smp_reg <= in_data[95:32];
            ndp_reg <= nd_enable && any_nd;
            cnt_reg <= cnt_next;
            sum_reg <= sum_next;
            item_reg <= '{x0: x0, x1: x1, y0: y0, y1: y1, fx: fx, fy: fy,
                          nd_path: ndp_reg, nd_count: cnt_reg, nd_sum: sum_reg,
                          samples: smp_reg};
        end
    end

    assign out_valid = v2_reg;
    assign out_item = item_reg;
endmodule

FILE: rtl/core/bss_queue.sv
module bss_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  bss_pkg::bss_item_t in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output bss_pkg::bss_item_t out_item
);
    import bss_pkg::*;

    // Two-entry queue between front and back.
    bss_item_t mem_reg [2];
    logic      wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic      push, pop;

    assign in_ready = cnt_reg != 2'd2;
    assign out_valid = cnt_reg != 2'd0;
    assign push = in_valid && in_ready;
    assign pop = out_valid && out_ready;
    assign out_item = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= !wp_reg;
            if (pop) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= in_item;
    end
endmodule

FILE: rtl/core/bss_back.sv
module bss_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  bss_pkg::bss_item_t in_item,
    input  logic [15:0]        nd_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [68:0]        out_data
);
    import bss_pkg::*;

    // Stage 1 weights, stage 2 weighted products, stage 3 sum and select.
    logic        adv;
    logic        v1_reg, v2_reg, v3_reg;
    bss_item_t   it1_reg, it2_reg;
    logic [33:0] w_reg [4];
    logic [33:0] w_next [4];
    logic [49:0] p_reg [4];
    logic [16:0] gx, gy;
    logic [15:0] avg;
    logic [15:0] bil;
    logic [51:0] acc;
    logic [35:0] div3;
    logic [15:0] res;
    logic [68:0] data_reg;

    assign adv = !v3_reg || out_ready;
    assign in_ready = adv;

    always_comb begin
        gx = 17'h10000 - {1'b0, in_item.fx};
        gy = 17'h10000 - {1'b0, in_item.fy};
        w_next[0] = gx * gy;
        w_next[1] = {1'b0, in_item.fx} * gy;
        w_next[2] = gx * {1'b0, in_item.fy};
        w_next[3] = {17'd0, in_item.fx} * {17'd0, in_item.fy};
    end

    always_comb begin
        acc = {2'b00, p_reg[0]} + {2'b00, p_reg[1]} + {2'b00, p_reg[2]} + {2'b00, p_reg[3]};
        bil = acc[47:32];
        // Division by three through the reciprocal 2^19/3, exact for sums below 2^19.
        div3 = {18'd0, it2_reg.nd_sum} * 36'd174763;
        case (it2_reg.nd_count)
            3'd1: avg = it2_reg.nd_sum[15:0];
            3'd2: avg = it2_reg.nd_sum[16:1];
            3'd3: avg = div3[34:19];
            default: avg = nd_value;
        endcase
        res = it2_reg.nd_path ? avg : bil;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            it1_reg <= in_item;
            it2_reg <= it1_reg;
            for (int k = 0; k < 4; k++) begin
                w_reg[k] <= w_next[k];
                p_reg[k] <= w_reg[k] * it1_reg.samples[16*k +: 16];
            end
            data_reg <= {it2_reg.nd_path, it2_reg.y1, it2_reg.y0,
                         it2_reg.x1, it2_reg.x0, res};
        end
    end

    assign out_valid = v3_reg;
    assign out_data = data_reg;
endmodule

FILE: rtl/core/bilinear_stretch_sampler.sv
// Channel   Dir  Width  Beat contents
// s_axis    in   96     dest_x, dest_y, top_left, top_right, bottom_left, bottom_right
// m_axis    out  72     sample_out, src_x0, src_x1, src_y0, src_y1, nodata_path
// cfg       in   3+32   register index, write data
// One beat is accepted each cycle unless a full queue stalls the front part. A beat
// passes the mapper's product register, the front part's item register, the queue's
// storage and the weight, product and output registers of the weighting pipeline.
// The 17x32 position product and the 34x16 sample products each take their own stage.
// Synchronous reset on aresetn low clears valid flags, queue state and config registers.
// A stall on m_axis freezes the back pipeline and then fills the two-entry queue before
// the front part stops taking beats.
module bilinear_stretch_sampler (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // dest_x[15:0], dest_y[31:16], top_left, top_right, bottom_left, bottom_right
    input  logic [95:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // sample_out[15:0], src_x0[28:16], src_x1[41:29], src_y0[54:42], src_y1[67:55],
    // nodata_path[68], zero fill
    output logic [71:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import bss_pkg::*;

    // Registers are fixed to sixteen-bit samples in this build.
    logic [SAMPLE_BITS-1:0] nd_value_reg;
    logic [31:0] scale_x_reg, scale_y_reg, offset_x_reg, offset_y_reg;
    logic [13:0] width_reg, height_reg;
    logic        nd_enable_reg;
    logic        f_valid, f_ready, q_valid, q_ready;
    bss_item_t   f_item, q_item;
    logic [68:0] b_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_x_reg <= 32'd65536;
            scale_y_reg <= 32'd65536;
            offset_x_reg <= '0;
            offset_y_reg <= '0;
            width_reg <= 14'd8192;
            height_reg <= 14'd8192;
            nd_enable_reg <= 1'b0;
            nd_value_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_SCALE_X:    scale_x_reg <= cfg_data;
                REG_SCALE_Y:    scale_y_reg <= cfg_data;
                REG_OFFSET_X:   offset_x_reg <= cfg_data;
                REG_OFFSET_Y:   offset_y_reg <= cfg_data;
                REG_SRC_WIDTH:  width_reg <= cfg_data[13:0];
                REG_SRC_HEIGHT: height_reg <= cfg_data[13:0];
                REG_ND_ENABLE:  nd_enable_reg <= cfg_data[0];
                REG_ND_VALUE:   nd_value_reg <= cfg_data[SAMPLE_BITS-1:0];
                default: ;
            endcase
        end
    end

    bss_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_data(s_axis_tdata),
        .scale_x(scale_x_reg), .scale_y(scale_y_reg),
        .offset_x(offset_x_reg), .offset_y(offset_y_reg),
        .src_width(width_reg), .src_height(height_reg),
        .nd_enable(nd_enable_reg), .nd_value(nd_value_reg[15:0]),
        .out_valid(f_valid), .out_ready(f_ready), .out_item(f_item)
    );

    bss_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(f_valid), .in_ready(f_ready), .in_item(f_item),
        .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
    );

    bss_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
        .nd_value(nd_value_reg[15:0]),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(b_data)
    );

    assign m_axis_tdata = {3'd0, b_data};

    // Clamped indices never exceed 8191, the right neighbour never trails, and no-data stays off.
    a_x_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[41:29] >= m_axis_tdata[28:16])
        else $error("src_x1 below src_x0");
    a_y_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[67:55] >= m_axis_tdata[54:42])
        else $error("src_y1 below src_y0");
    a_nd_off: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !nd_enable_reg) |-> !m_axis_tdata[68])
        else $error("no-data path with detection disabled");
endmodule

FILE: tb/sv/bilinear_stretch_sampler_test.sv
module bilinear_stretch_sampler_test;
    timeunit 1ns;
    timeprecision 1ps;
    import bss_pkg::*;

    // One destination pixel as the block sees it on the input channel.
    typedef struct {
        logic [15:0] dest_x;
        logic [15:0] dest_y;
        logic [15:0] tl;
        logic [15:0] tr;
        logic [15:0] bl;
        logic [15:0] br;
    } pixel_t;

    // The expected output beat for one pixel.
    typedef struct {
        logic [15:0] sample;
        logic [12:0] x0;
        logic [12:0] x1;
        logic [12:0] y0;
        logic [12:0] y1;
        logic        nd_path;
    } resample_t;

    // Scoreboard: keeps its own copy of the registers, predicts each sample and
    // compares the output beats in order.
    class resample_board;
        logic [31:0] scale_x, scale_y;
        logic signed [31:0] offset_x, offset_y;
        logic [13:0] width, height;
        logic        nd_enable;
        logic [15:0] nd_value;
        resample_t   pending[$];
        int          mismatches;

        function void reset_regs();
            scale_x = 32'd65536;
            scale_y = 32'd65536;
            offset_x = 0;
            offset_y = 0;
            width = 14'd8192;
            height = 14'd8192;
            nd_enable = 1'b0;
            nd_value = 16'd0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] data);
            case (idx)
                REG_SCALE_X:    scale_x = data;
                REG_SCALE_Y:    scale_y = data;
                REG_OFFSET_X:   offset_x = data;
                REG_OFFSET_Y:   offset_y = data;
                REG_SRC_WIDTH:  width = data[13:0];
                REG_SRC_HEIGHT: height = data[13:0];
                REG_ND_ENABLE:  nd_enable = data[0];
                REG_ND_VALUE:   nd_value = data[15:0];
                default: ;
            endcase
        endfunction

        // Maps one axis to its two clamped indices and the 16-bit fraction.
        function void map_axis(input logic [15:0] dest, input logic [31:0] scale,
                               input logic signed [31:0] offset, input logic [13:0] size,
                               output logic [12:0] i0, output logic [12:0] i1,
                               output logic [15:0] frac);
            logic [63:0] prod;
            logic signed [63:0] pos, idx;
            longint last;
            prod = ({48'd0, dest} * 2 + 1) * {32'd0, scale};
            pos = 64'(offset) + $signed(prod >> 1) - 64'sd32768;
            last = (size == 0) ? 0 : (size > 8192) ? 8191 : size - 1;
            frac = pos[15:0];
            idx = pos >>> 16;
            if (idx < 0) begin
                i0 = '0;
                i1 = '0;
            end else begin
                if (idx > last) idx = last;
                i0 = idx[12:0];
                i1 = (idx + 1 > last) ? last[12:0] : 13'(idx + 1);
            end
        endfunction

        function void note_pixel(pixel_t p);
            resample_t r;
            logic [15:0] fx, fy;
            logic [16:0] gx, gy;
            logic [15:0] s[4];
            logic [127:0] acc;
            logic [17:0] sum;
            int cnt;
            bit any_nd;
            map_axis(p.dest_x, scale_x, offset_x, width, r.x0, r.x1, fx);
            map_axis(p.dest_y, scale_y, offset_y, height, r.y0, r.y1, fy);
            s[0] = p.tl; s[1] = p.tr; s[2] = p.bl; s[3] = p.br;
            any_nd = 0; sum = 0; cnt = 0;
            for (int k = 0; k < 4; k++) begin
                if (s[k] == nd_value) any_nd = 1;
                else begin
                    sum += s[k];
                    cnt++;
                end
            end
            if (nd_enable && any_nd) begin
                r.sample = (cnt != 0) ? 16'(sum / cnt) : nd_value;
                r.nd_path = 1'b1;
            end else begin
                gx = 17'd65536 - fx;
                gy = 17'd65536 - fy;
                acc = 128'(s[0]) * gx * gy + 128'(s[1]) * fx * gy
                    + 128'(s[2]) * gx * fy + 128'(s[3]) * fx * fy;
                r.sample = acc[47:32];
                r.nd_path = 1'b0;
            end
            pending.push_back(r);
        endfunction

        function void check_beat(logic [71:0] d);
            resample_t e;
            bit bad;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected output beat %h", d);
                return;
            end
            e = pending.pop_front();
            bad = d[15:0] != e.sample || d[28:16] != e.x0 || d[41:29] != e.x1
                || d[54:42] != e.y0 || d[67:55] != e.y1 || d[68] != e.nd_path;
            if (bad) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: sample %h/%h x0 %0d/%0d x1 %0d/%0d y0 %0d/%0d y1 %0d/%0d nd %b/%b (exp/got)",
                             e.sample, d[15:0], e.x0, d[28:16], e.x1, d[41:29],
                             e.y0, d[54:42], e.y1, d[67:55], e.nd_path, d[68]);
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [71:0] m_axis_tdata;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    resample_board board = new();
    // While set, the receiver holds off so that the pipeline and queue fill up.
    bit hold_off = 0;
    int stall_mode = 0;

    bilinear_stretch_sampler u_top (.*);

    always begin
        #6 aclk = 1;
        #6 aclk = 0;
    end

    // Receiver: checks every accepted beat, and stalls on a pattern chosen per phase.
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) board.check_beat(m_axis_tdata);
        case (stall_mode)
            0: m_axis_tready <= !hold_off;
            1: m_axis_tready <= !hold_off && ($urandom_range(0, 3) != 0);
            default: m_axis_tready <= !hold_off && ($urandom_range(0, 1) != 0);
        endcase
    end

    // Each write ends with cfg_valid low again so that writes never overlap.
    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        board.write_reg(idx, data);
        cfg_valid <= 0;
        @(posedge aclk);
    endtask

    // Offers one pixel and waits for it to be taken; the prediction is made at acceptance.
    task automatic send_pixel(pixel_t p);
        s_axis_tvalid <= 1;
        s_axis_tdata <= {p.br, p.bl, p.tr, p.tl, p.dest_y, p.dest_x};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        board.note_pixel(p);
    endtask

    task automatic idle_cycles(int n);
        s_axis_tvalid <= 0;
        repeat (n) @(posedge aclk);
    endtask

    // Waits until every expected beat has arrived, then lets the pipeline settle.
    task automatic drain();
        s_axis_tvalid <= 0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    function automatic pixel_t rand_pixel(logic [15:0] nd);
        pixel_t p;
        p.dest_x = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
        p.dest_y = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
        p.tl = 16'($urandom); p.tr = 16'($urandom);
        p.bl = 16'($urandom); p.br = 16'($urandom);
        // Plant no-data samples often enough to exercise the averaging path.
        if ($urandom_range(0, 2) == 0) begin
            if ($urandom_range(0, 1)) p.tl = nd;
            if ($urandom_range(0, 1)) p.tr = nd;
            if ($urandom_range(0, 1)) p.bl = nd;
            if ($urandom_range(0, 1)) p.br = nd;
        end
        return p;
    endfunction

    // Sender in bursts of random length, separated at times by random gaps.
    task automatic random_burst_phase(int count);
        int left;
        left = count;
        while (left > 0) begin
            int burst;
            burst = $urandom_range(1, 20);
            for (int i = 0; i < burst && left > 0; i++, left--)
                send_pixel(rand_pixel(board.nd_value));
            if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 8));
        end
    endtask

    function automatic pixel_t mk(int x, int y, int a, int b, int c, int d);
        pixel_t p;
        p.dest_x = 16'(x); p.dest_y = 16'(y); p.tl = 16'(a); p.tr = 16'(b);
        p.bl = 16'(c); p.br = 16'(d);
        return p;
    endfunction

    initial begin
        board.reset_regs();
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: reset settings, extremes of the destination and the samples.
        send_pixel(mk(0, 0, 0, 0, 0, 0));
        send_pixel(mk(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_pixel(mk(1, 2, 16'hFFFF, 0, 16'h1234, 16'h8000));
        drain();

        // Half-pixel scale with a negative offset: negative index and fractions.
        write_reg(REG_SCALE_X, 32'h0000_8000);
        write_reg(REG_SCALE_Y, 32'h0001_8001);
        write_reg(REG_OFFSET_X, 32'hFFFE_0000);
        write_reg(REG_OFFSET_Y, 32'h0000_4321);
        write_reg(REG_SRC_WIDTH, 32'd5);
        write_reg(REG_SRC_HEIGHT, 32'd1);
        send_pixel(mk(0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_pixel(mk(3, 1, 100, 200, 300, 400));
        send_pixel(mk(16'hFFFF, 7, 16'hFFFF, 0, 0, 16'hFFFF));
        drain();

        // Widest scale and offset, size zero and above the limit, no-data on.
        write_reg(REG_SCALE_X, 32'hFFFF_FFFF);
        write_reg(REG_SCALE_Y, 32'h0000_0000);
        write_reg(REG_OFFSET_X, 32'h7FFF_FFFF);
        write_reg(REG_OFFSET_Y, 32'h8000_0000);
        write_reg(REG_SRC_WIDTH, 32'd0);
        write_reg(REG_SRC_HEIGHT, 32'h3FFF);
        write_reg(REG_ND_ENABLE, 32'd1);
        write_reg(REG_ND_VALUE, 32'hFFFF);
        send_pixel(mk(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_pixel(mk(5, 5, 16'hFFFF, 16'hFFFE, 16'hFFFE, 16'hFFFF));
        send_pixel(mk(0, 0, 1, 2, 16'hFFFF, 4));
        send_pixel(mk(9, 9, 1, 2, 3, 4));
        drain();

        write_reg(REG_OFFSET_X, 32'h8000_0000);
        write_reg(REG_OFFSET_Y, 32'h7FFF_FFFF);
        write_reg(REG_SRC_WIDTH, 32'd8192);
        write_reg(REG_SRC_HEIGHT, 32'd8193);
        write_reg(REG_ND_VALUE, 32'd0);
        send_pixel(mk(16'hFFFF, 0, 0, 0, 0, 0));
        send_pixel(mk(0, 16'hFFFF, 0, 7, 8, 0));
        drain();

        // Random phases, each under fresh registers and one of three stall patterns in turn.
        for (int ph = 0; ph < 6; ph++) begin
            stall_mode = ph % 3;
            write_reg(REG_SCALE_X, ($urandom_range(0, 3) == 0) ? $urandom
                                                               : $urandom_range(0, 32'h40000));
            write_reg(REG_SCALE_Y, ($urandom_range(0, 3) == 0) ? $urandom
                                                               : $urandom_range(0, 32'h40000));
            write_reg(REG_OFFSET_X, ($urandom_range(0, 3) == 0) ? $urandom
                                                : 32'($signed($urandom_range(0, 32'h600000)) - 32'sh300000));
            write_reg(REG_OFFSET_Y, ($urandom_range(0, 3) == 0) ? $urandom
                                                : 32'($signed($urandom_range(0, 32'h600000)) - 32'sh300000));
            write_reg(REG_SRC_WIDTH, $urandom_range(0, 32'h3FFF));
            write_reg(REG_SRC_HEIGHT, ($urandom_range(0, 1)) ? $urandom_range(1, 64)
                                                             : $urandom_range(0, 32'h3FFF));
            write_reg(REG_ND_ENABLE, 32'(ph % 2 == 0));
            write_reg(REG_ND_VALUE, ($urandom_range(0, 1)) ? 32'($urandom_range(0, 3)) : $urandom);

            if (ph == 1) begin
                // The receiver holds off for a long stretch while pixels keep coming.
                fork
                    begin
                        hold_off = 1;
                        repeat (60) @(posedge aclk);
                        hold_off = 0;
                    end
                    random_burst_phase(40);
                join
            end
            random_burst_phase(240);
            // The sender pauses here until every expected beat has come.
            drain();
        end

        if (board.mismatches == 0 && board.pending.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("status: fail");
        $finish;
    end
endmodule

FILE: sim.f
rtl/core/bss_pkg.sv
rtl/core/bss_axis_map.sv
rtl/core/bss_front.sv
rtl/core/bss_queue.sv
rtl/core/bss_back.sv
rtl/core/bilinear_stretch_sampler.sv
tb/sv/bilinear_stretch_sampler_test.sv
